// File: sv/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared widths, register codes and stage records for the grid rounding core.
// ----------------------------------------------------------------------------
package tgr_pkg;

   localparam int TIME_WIDTH = 64;            // arithmetic width, 32..64
   localparam int STEP_W     = 63;            // step register width
   localparam int WIDE_W     = STEP_W + 1;    // trial remainder / headroom compare
   localparam int OUT_W      = 64;            // port width of timestamps
   localparam int CSR_IDX_W  = 2;
   localparam int LATENCY    = TIME_WIDTH + 4; // 2 front + one cell per bit + 2 back

   typedef logic [TIME_WIDTH-1:0]   time_type;
   typedef logic [STEP_W-1:0]       step_type;
   typedef logic [WIDE_W-1:0]       wide_type;
   typedef logic signed [OUT_W-1:0] out_time_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_NS     = 2'd0,
      CSR_GRID_ORIGIN = 2'd1
   } csr_index_type;

   // record that walks down the divider chain
   typedef struct packed {
      logic     valid;
      logic     ceil_op;
      logic     neg;
      logic     ovf;
      time_type t;
      time_type mag;
      time_type bits;   // dividend bits not yet consumed, MSB first
      step_type rem;    // partial remainder, always below the step
   } cell_data_type;

endpackage

// File: sv/tgr_front.sv
// ----------------------------------------------------------------------------
// tgr_front
// Forms the offset from the grid origin and its magnitude for the divider.
// ----------------------------------------------------------------------------
module tgr_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    ceil_op,
   input  tgr_pkg::time_type       t,
   input  tgr_pkg::time_type       origin,
   output tgr_pkg::cell_data_type  out_data
);

   logic              valid_ff, valid_in;
   logic              ceil_ff, ceil_in;
   logic              ovf_ff, ovf_in;
   tgr_pkg::time_type t_ff, t_in;
   tgr_pkg::time_type d_ff, d_in;
   logic              neg;
   tgr_pkg::cell_data_type out_ff, out_in;

   always_comb begin
      valid_in = accept;
      ceil_in  = ceil_op;
      t_in     = t;
      d_in     = t - origin;
      ovf_in   = (t[tgr_pkg::TIME_WIDTH-1] != origin[tgr_pkg::TIME_WIDTH-1]) &&
                 (d_in[tgr_pkg::TIME_WIDTH-1] != t[tgr_pkg::TIME_WIDTH-1]);
   end

   always_comb begin
      neg             = d_ff[tgr_pkg::TIME_WIDTH-1];
      out_in.valid    = valid_ff;
      out_in.ceil_op  = ceil_ff;
      out_in.neg      = neg;
      out_in.ovf      = ovf_ff;
      out_in.t        = t_ff;
      out_in.mag      = neg ? (~d_ff + tgr_pkg::time_type'(1)) : d_ff;
      out_in.bits     = out_in.mag;
      out_in.rem      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_ff.valid <= out_in.valid;
      end
      ceil_ff          <= ceil_in;
      ovf_ff           <= ovf_in;
      t_ff             <= t_in;
      d_ff             <= d_in;
      out_ff.ceil_op   <= out_in.ceil_op;
      out_ff.neg       <= out_in.neg;
      out_ff.ovf       <= out_in.ovf;
      out_ff.t         <= out_in.t;
      out_ff.mag       <= out_in.mag;
      out_ff.bits      <= out_in.bits;
      out_ff.rem       <= out_in.rem;
   end

   assign out_data = out_ff;

endmodule

// File: sv/tgr_cell.sv
// ----------------------------------------------------------------------------
// tgr_cell
// One restoring-division step: brings in one dividend bit, keeps the remainder.
// ----------------------------------------------------------------------------
module tgr_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  tgr_pkg::step_type       step,
   input  tgr_pkg::cell_data_type  in_data,
   output tgr_pkg::cell_data_type  out_data
);

   tgr_pkg::wide_type      trial;
   tgr_pkg::wide_type      step_wide;
   tgr_pkg::cell_data_type data_ff, data_in;

   always_comb begin
      trial     = {in_data.rem, in_data.bits[tgr_pkg::TIME_WIDTH-1]};
      step_wide = tgr_pkg::wide_type'(step);
      data_in      = in_data;
      data_in.bits = in_data.bits << 1;
      if (trial >= step_wide) begin
         data_in.rem = tgr_pkg::step_type'(trial - step_wide);
      end else begin
         data_in.rem = tgr_pkg::step_type'(trial);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff.valid <= data_in.valid;
      end
      data_ff.ceil_op <= data_in.ceil_op;
      data_ff.neg     <= data_in.neg;
      data_ff.ovf     <= data_in.ovf;
      data_ff.t       <= data_in.t;
      data_ff.mag     <= data_in.mag;
      data_ff.bits    <= data_in.bits;
      data_ff.rem     <= data_in.rem;
   end

   assign out_data = data_ff;

endmodule

// File: sv/tgr_back.sv
// ----------------------------------------------------------------------------
// tgr_back
// Rebuilds the truncated grid point from the remainder and applies the
// floor / ceiling correction with overflow detection.
// ----------------------------------------------------------------------------
module tgr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  tgr_pkg::step_type       step,
   input  tgr_pkg::time_type       origin,
   input  tgr_pkg::cell_data_type  in_data,
   output logic                    rsp_valid,
   output tgr_pkg::out_time_type   rsp_rounded_time,
   output logic                    rsp_overflow
);

   localparam int MSB = tgr_pkg::TIME_WIDTH - 1;

   // first stage: truncated point r = +/-(mag - rem) + origin
   logic              valid_ff, valid_in;
   logic              ceil_ff, ceil_in;
   logic              ovf_ff, ovf_in;
   tgr_pkg::time_type t_ff, t_in;
   tgr_pkg::time_type r_ff, r_in;
   tgr_pkg::time_type rem_t;
   tgr_pkg::time_type p;

   // second stage: correction
   logic                  out_valid_ff, out_valid_in;
   tgr_pkg::out_time_type out_time_ff, out_time_in;
   logic                  out_ovf_ff, out_ovf_in;
   tgr_pkg::time_type     u;
   tgr_pkg::time_type     u_inv;
   tgr_pkg::time_type     step_t;
   tgr_pkg::wide_type     step_wide;
   tgr_pkg::time_type     r_fix;
   logic                  ovf_fix;

   always_comb begin
      rem_t    = tgr_pkg::time_type'(in_data.rem);
      p        = in_data.neg ? (rem_t - in_data.mag) : (in_data.mag - rem_t);
      r_in     = p + origin;
      valid_in = in_data.valid;
      ceil_in  = in_data.ceil_op;
      t_in     = in_data.t;
      ovf_in   = in_data.ovf ||
                 ((p[MSB] == origin[MSB]) && (r_in[MSB] != p[MSB]));
   end

   always_comb begin
      // u = r + 2^(W-1): room below r; its complement is room above r
      u         = {~r_ff[MSB], r_ff[MSB-1:0]};
      u_inv     = ~u;
      step_t    = tgr_pkg::time_type'(step);
      step_wide = tgr_pkg::wide_type'(step);
      r_fix     = r_ff;
      ovf_fix   = ovf_ff;
      if (!ceil_ff) begin
         if ($signed(t_ff) < $signed(r_ff)) begin
            ovf_fix = ovf_ff || (step_wide > tgr_pkg::wide_type'(u));
            r_fix   = r_ff - step_t;
         end
      end else begin
         if ($signed(r_ff) < $signed(t_ff)) begin
            ovf_fix = ovf_ff || (step_wide > tgr_pkg::wide_type'(u_inv));
            r_fix   = r_ff + step_t;
         end
      end
      out_valid_in = valid_ff;
      out_time_in  = tgr_pkg::out_time_type'($signed(r_fix));
      out_ovf_in   = ovf_fix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
      ceil_ff     <= ceil_in;
      ovf_ff      <= ovf_in;
      t_ff        <= t_in;
      r_ff        <= r_in;
      out_time_ff <= out_time_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_rounded_time = out_time_ff;
   assign rsp_overflow     = out_ovf_ff;

endmodule

// File: sv/timestamp_grid_round_core.sv
// ----------------------------------------------------------------------------
// timestamp_grid_round_core
// Rounds signed nanosecond timestamps down or up onto a grid of given step
// and origin.
// ----------------------------------------------------------------------------
// Takes one timestamp per clock (busy is low except during reset) and
// returns its result on rsp_valid, in order. The path runs through the
// front stages (offset, magnitude), the divider chain of one cell per
// dividend bit, each taking in one dividend bit, and the back stages
// (rebuild, correction). Results come out as one-cycle strobes and cannot
// be held off, so the receiver must take every beat. Write step_ns and
// grid_origin only while no request is in flight; a step of zero acts as
// one.
// ----------------------------------------------------------------------------
module timestamp_grid_round_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_operation,
   input  logic signed [tgr_pkg::OUT_W-1:0]     req_timestamp,
   output logic                                 rsp_valid,
   output logic signed [tgr_pkg::OUT_W-1:0]     rsp_rounded_time,
   output logic                                 rsp_overflow,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tgr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tgr_pkg::OUT_W-1:0]            csr_wdata
);

   tgr_pkg::step_type step_ff, step_in;
   tgr_pkg::time_type origin_ff, origin_in;
   tgr_pkg::step_type step_eff;
   logic              accept;

   tgr_pkg::cell_data_type chain [tgr_pkg::TIME_WIDTH+1];

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      step_in   = step_ff;
      origin_in = origin_ff;
      if (csr_valid && csr_ready) begin
         case (tgr_pkg::csr_index_type'(csr_index))
            tgr_pkg::CSR_STEP_NS: begin
               step_in = tgr_pkg::step_type'(csr_wdata);
            end
            tgr_pkg::CSR_GRID_ORIGIN: begin
               origin_in = tgr_pkg::time_type'(csr_wdata);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= tgr_pkg::step_type'(1);
         origin_ff <= '0;
      end else begin
         step_ff   <= step_in;
         origin_ff <= origin_in;
      end
   end

   assign step_eff = (step_ff == '0) ? tgr_pkg::step_type'(1) : step_ff;

   tgr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .ceil_op  (req_operation),
      .t        (tgr_pkg::time_type'(req_timestamp)),
      .origin   (origin_ff),
      .out_data (chain[0])
   );

   for (genvar k = 0; k < tgr_pkg::TIME_WIDTH; k++) begin : g_cell
      tgr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (step_eff),
         .in_data  (chain[k]),
         .out_data (chain[k+1])
      );
   end

   tgr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .step             (step_eff),
      .origin           (origin_ff),
      .in_data          (chain[tgr_pkg::TIME_WIDTH]),
      .rsp_valid        (rsp_valid),
      .rsp_rounded_time (rsp_rounded_time),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

// File: sv/tgr_checker.sv
// ----------------------------------------------------------------------------
// tgr_checker
// Port-level timing checks for the grid rounding core.
// ----------------------------------------------------------------------------
module tgr_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_valid,
   input logic csr_ready
);

   // every accepted beat comes back after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(tgr_pkg::LATENCY) rsp_valid)
      else $error("accepted request produced no result at fixed latency");

   // and no result appears without a request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##(tgr_pkg::LATENCY) !rsp_valid)
      else $error("result strobe without matching request");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind timestamp_grid_round_core tgr_checker u_tgr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
